/* hdl/rsdd_pkg.sv */
`default_nettype none

package rsdd_pkg;

  // Draw geometry
  localparam int PICK_COUNT   = 6;
  localparam int RANGE_TOP    = 90;
  localparam int MAX_ATTEMPTS = 65536;

  // Field widths
  localparam int SEED_W = 32;
  localparam int TAG_W  = 8;
  localparam int POS_W  = 3;
  localparam int VAL_W  = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Generator constants
  localparam logic [SEED_W-1:0] SEED_XOR  = 32'hDEEC_E66D;
  localparam logic [SEED_W-1:0] SEED_INIT = 32'd1;
  localparam logic [15:0]       MULT_Z    = 16'd36969;
  localparam logic [15:0]       MULT_W    = 16'd18000;

  // Counter widths
  localparam int ATT_W = $clog2(MAX_ATTEMPTS);
  localparam int CNT_W = $clog2(PICK_COUNT + 1);
  localparam int IDX_W = (PICK_COUNT > 1) ? $clog2(PICK_COUNT) : 1;

  // Reduction modulo RANGE_TOP: fold the upper half with 2^16 mod RANGE_TOP,
  // then divide by a scaled reciprocal that never overestimates the quotient.
  localparam int FOLD_K   = (1 << 16) % RANGE_TOP;
  localparam int FOLD_W   = 23;
  localparam int RECIP_SH = FOLD_W + 1;
  localparam int RECIP_M  = (1 << RECIP_SH) / RANGE_TOP;
  localparam int RECIP_W  = RECIP_SH - 3;
  localparam int PROD_W   = FOLD_W + RECIP_W;
  localparam int Q_W      = PROD_W - RECIP_SH;
  localparam int REM_W    = VAL_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FILL,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             draw_en;
    logic             fill_en;
    logic             sort_en;
    logic             load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic draw_done;
    logic count_full;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/rsdd_ctrl.sv */
`default_nettype none

module rsdd_ctrl
  import rsdd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  req_valid,
  output logic       req_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    req_ready = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd.draw_en = 1'b1;
        if (stat.draw_done) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_en = 1'b1;
        if (stat.count_full) begin
          idx_nxt   = '0;
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        if (idx_r == IDX_W'(PICK_COUNT - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (idx_r == IDX_W'(PICK_COUNT - 1)) begin
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rsdd_dp.sv */
`default_nettype none

module rsdd_dp
  import rsdd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              seed_we,
  input  wire logic [SEED_W-1:0] seed,
  input  wire logic [TAG_W-1:0]  req_tag,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic              res_ready,
  output logic                   res_valid,
  output logic [TAG_W-1:0]       res_tag,
  output logic [POS_W-1:0]       res_pos,
  output logic [VAL_W-1:0]       res_val,
  output logic                   res_last
);

  // Generators and the three-stage reduction pipeline.
  logic [SEED_W-1:0] gen_z_r, gen_w_r, gen_z_nxt, gen_w_nxt;
  logic              v0_r, va_r, vb_r;
  logic [FOLD_W-1:0] fold_r, foldb_r, fold_s;
  logic [SEED_W-1:0] za_r, wa_r, zb_r, wb_r;
  logic [Q_W-1:0]    q_r;
  logic [SEED_W-1:0] draw_s;
  logic [PROD_W-1:0] prod_s;
  logic [FOLD_W-1:0] rem_s;
  logic [REM_W-1:0]  rem8_s, red_s;
  logic [VAL_W-1:0]  val_s;

  // Selection state.
  logic [ATT_W-1:0]   att_r;
  logic [CNT_W-1:0]   count_r;
  logic [VAL_W-1:0]   scan_r;
  logic [TAG_W-1:0]   tag_r;
  logic [VAL_W-1:0]   picked_r [PICK_COUNT];
  logic [VAL_W-1:0]   picked_nxt [PICK_COUNT];

  logic             check_s, hit_s, seen_s, finish_s, step_s;
  logic             wr_en, room_s;
  logic [VAL_W-1:0] wr_val;
  logic [VAL_W-1:0] swap_tmp;

  logic             out_valid_r;
  logic [TAG_W-1:0] out_tag_r;
  logic [POS_W-1:0] out_pos_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_last_r;

  assign gen_z_nxt = MULT_Z * gen_z_r[15:0] + {16'h0, gen_z_r[31:16]};
  assign gen_w_nxt = MULT_W * gen_w_r[15:0] + {16'h0, gen_w_r[31:16]};

  // draw = (z << 16) + w, folded so that its residue is kept in FOLD_W bits.
  assign draw_s = {gen_z_r[15:0], 16'h0} + gen_w_r;
  assign fold_s = FOLD_W'(draw_s[31:16]) * FOLD_W'(FOLD_K) + FOLD_W'(draw_s[15:0]);

  assign prod_s = PROD_W'(fold_r) * PROD_W'(RECIP_M);

  // The quotient is exact or one low, so one subtraction finishes the residue.
  assign rem_s  = foldb_r - FOLD_W'(q_r) * FOLD_W'(RANGE_TOP);
  assign rem8_s = rem_s[REM_W-1:0];
  assign red_s  = (rem8_s >= REM_W'(RANGE_TOP)) ? rem8_s - REM_W'(RANGE_TOP) : rem8_s;
  assign val_s  = red_s[VAL_W-1:0] + 1'b1;

  // A value is already used when it matches one of the picks held so far.
  always_comb begin
    hit_s  = 1'b0;
    seen_s = 1'b0;
    for (int i = 0; i < PICK_COUNT; i++) begin
      if (CNT_W'(i) < count_r) begin
        hit_s  = hit_s | (picked_r[i] == val_s);
        seen_s = seen_s | (picked_r[i] == scan_r);
      end
    end
  end

  assign room_s   = (count_r < CNT_W'(PICK_COUNT));
  assign check_s  = cmd.draw_en & vb_r;
  assign finish_s = check_s & ((~hit_s & (count_r == CNT_W'(PICK_COUNT - 1))) |
                               (att_r == ATT_W'(MAX_ATTEMPTS - 1)));
  assign step_s   = cmd.draw_en & ~finish_s;

  assign wr_en  = (check_s & ~hit_s) | (cmd.fill_en & room_s & ~seen_s);
  assign wr_val = cmd.draw_en ? val_s : scan_r;

  always_comb begin
    swap_tmp = '0;
    for (int i = 0; i < PICK_COUNT; i++) begin
      picked_nxt[i] = picked_r[i];
    end
    if (wr_en) begin
      picked_nxt[count_r[IDX_W-1:0]] = wr_val;
    end
    // Odd-even transposition: one phase per cycle over disjoint pairs.
    if (cmd.sort_en) begin
      for (int i = 0; i < PICK_COUNT - 1; i++) begin
        if ((i % 2) == int'(cmd.idx[0]) && picked_r[i] > picked_r[i+1]) begin
          swap_tmp        = picked_r[i];
          picked_nxt[i]   = picked_r[i+1];
          picked_nxt[i+1] = swap_tmp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_z_r     <= SEED_INIT;
      gen_w_r     <= SEED_INIT ^ SEED_XOR;
      v0_r        <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (seed_we) begin
        gen_z_r <= seed;
        gen_w_r <= seed ^ SEED_XOR;
      end else if (finish_s) begin
        // Rewind to the state that produced the final draw.
        gen_z_r <= zb_r;
        gen_w_r <= wb_r;
      end else if (step_s) begin
        gen_z_r <= gen_z_nxt;
        gen_w_r <= gen_w_nxt;
      end
      if (cmd.start) begin
        v0_r <= 1'b0;
        va_r <= 1'b0;
        vb_r <= 1'b0;
      end else begin
        v0_r <= step_s;
        va_r <= step_s & v0_r;
        vb_r <= step_s & va_r;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fold_r  <= fold_s;
    za_r    <= gen_z_r;
    wa_r    <= gen_w_r;
    q_r     <= prod_s[PROD_W-1:RECIP_SH];
    foldb_r <= fold_r;
    zb_r    <= za_r;
    wb_r    <= wa_r;
    for (int i = 0; i < PICK_COUNT; i++) begin
      picked_r[i] <= picked_nxt[i];
    end
    if (cmd.start) begin
      att_r   <= '0;
      count_r <= '0;
      scan_r  <= VAL_W'(1);
      tag_r   <= req_tag;
    end else begin
      if (check_s) begin
        att_r <= att_r + 1'b1;
      end
      if (cmd.fill_en && room_s) begin
        scan_r <= scan_r + 1'b1;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
    end
    if (cmd.load) begin
      out_tag_r  <= tag_r;
      out_pos_r  <= POS_W'(cmd.idx);
      out_val_r  <= picked_r[cmd.idx];
      out_last_r <= (cmd.idx == IDX_W'(PICK_COUNT - 1));
    end
  end

  assign stat.draw_done  = finish_s;
  assign stat.count_full = ~room_s;
  assign stat.out_free   = ~out_valid_r | res_ready;

  assign res_valid = out_valid_r;
  assign res_tag   = out_tag_r;
  assign res_pos   = out_pos_r;
  assign res_val   = out_val_r;
  assign res_last  = out_last_r;

endmodule

`default_nettype wire

/* hdl/random_sorted_distinct_draw_unit.sv */
// Draws six distinct values in 1..90 per request and returns them sorted.
// Input channel (in_): one transaction per request; in_tdata carries the
// column index, which is copied into every result of that request.
// Output channel (out_): six transactions per request in ascending order;
// out_tdata carries the column tag, the rank and the value, and out_tlast
// marks the sixth one. Configuration: a write on cfg_wr_en loads the seed
// into the z multiply-with-carry generator and seed ^ SEED_XOR into w; the
// user must write it only while the block is idle; the block does not enforce it.
// Timing: after a request is accepted, draws flow through a three-stage
// modulo pipeline at one draw per cycle, rejected repeats included. A
// fallback fill step tops up with the smallest unused values if the attempt
// limit ended the draw, the sort runs odd-even transposition phases, and the
// six results leave one per cycle while the receiver is ready.
// A new request is taken as soon as the last result has entered the output
// register, even while that result still waits for the receiver.
// If the receiver stalls, the output register holds its transaction and the
// controller waits before loading the next result; nothing is lost.
// Reset (rst_n low, synchronous) empties the output register, returns the
// controller to idle and loads the generators as if the seed were one.
`default_nettype none

module random_sorted_distinct_draw_unit
  import rsdd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] column_index
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [7:0] column_tag, [10:8] position,
                                                  // [17:11] drawn_value, [23:18] zero
  output logic                        out_tlast,  // last_value
  // Seed register.
  input  wire logic                   cfg_wr_en,
  input  wire logic [SEED_W-1:0]      cfg_wr_data
);

  cmd_t             cmd;
  stat_t            stat;
  logic [TAG_W-1:0] res_tag;
  logic [POS_W-1:0] res_pos;
  logic [VAL_W-1:0] res_val;

  // The controller sequences draw, fill, sort and emit.
  rsdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the generators, the repeat check, the picks and the
  // output register.
  rsdd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_we   (cfg_wr_en),
    .seed      (cfg_wr_data),
    .req_tag   (in_tdata[TAG_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .res_ready (out_tready),
    .res_valid (out_tvalid),
    .res_tag   (res_tag),
    .res_pos   (res_pos),
    .res_val   (res_val),
    .res_last  (out_tlast)
  );

  // Pack the result fields from the lowest bit up and pad to whole bytes.
  assign out_tdata = {(OUT_TDATA_W - TAG_W - POS_W - VAL_W)'(0), res_val, res_pos, res_tag};

endmodule

`default_nettype wire

/* hdl/rsdd_checker.sv */
`default_nettype none

module rsdd_checker
  import rsdd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // One request at a time: a request is never taken on consecutive edges.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // Every value lies in the drawn range.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:11] != 7'd0 && out_tdata[17:11] <= VAL_W'(RANGE_TOP))
    else $error("value out of range");

  // The last result carries the highest rank.
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[10:8] == POS_W'(PICK_COUNT - 1))
    else $error("last marker on wrong rank");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind random_sorted_distinct_draw_unit rsdd_checker u_rsdd_checker (.*);

`default_nettype wire

/* tb/tb_random_sorted_distinct_draw_unit.sv */
`timescale 1ns / 100ps

module tb_random_sorted_distinct_draw_unit;
  import rsdd_pkg::*;

  typedef enum logic {
    ROW_REQ,
    ROW_SEED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
  } stim_row_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic             last;
  } draw_result_t;

  // Seeds that park one generator at its nonzero fixed point: z for the
  // first, w (through seed ^ SEED_XOR) for the second.
  localparam logic [31:0] Z_FIXED_SEED = 32'h9068_FFFF;
  localparam logic [31:0] W_FIXED_SEED = 32'h98A3_1992;
  localparam int          DIRECTED_N   = 17;
  localparam int          RANDOM_ITEMS = 160;

  // Directed part: request extremes after reset, then every degenerate seed.
  localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
    '{ROW_REQ,  32'h0000_0000},
    '{ROW_REQ,  32'h0000_00FF},
    '{ROW_REQ,  32'h0000_005A},
    '{ROW_SEED, 32'h0000_0000},
    '{ROW_REQ,  32'h0000_00A5},
    '{ROW_REQ,  32'h0000_0001},
    '{ROW_SEED, 32'hFFFF_FFFF},
    '{ROW_REQ,  32'h0000_0080},
    '{ROW_REQ,  32'h0000_007F},
    '{ROW_SEED, SEED_XOR},
    '{ROW_REQ,  32'h0000_003C},
    '{ROW_REQ,  32'h0000_00C3},
    '{ROW_SEED, Z_FIXED_SEED},
    '{ROW_REQ,  32'h0000_0011},
    '{ROW_SEED, W_FIXED_SEED},
    '{ROW_REQ,  32'h0000_00EE},
    '{ROW_SEED, 32'h0000_0001}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // [7:0] column_index
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // [7:0] column_tag, [10:8] position,
                                        // [17:11] drawn_value, [23:18] zero
  logic                   out_tlast;    // last_value
  logic                   cfg_wr_en;
  logic [SEED_W-1:0]      cfg_wr_data;

  // Shadow copy of the two generators.
  logic [31:0]  gen_z_shadow;
  logic [31:0]  gen_w_shadow;
  draw_result_t pending_draws[$];
  int           mismatch_count = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;

  always #2 clk = ~clk;

  random_sorted_distinct_draw_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Works out the six sorted values of one request and queues them.
  task automatic predict_draw(input logic [TAG_W-1:0] tag);
    logic [RANGE_TOP:0] taken;
    logic [VAL_W-1:0]   vals [PICK_COUNT];
    logic [VAL_W-1:0]   tmp;
    logic [31:0]        draw;
    int                 count;
    int                 tries;
    int                 v;
    draw_result_t       r;
    taken = '0;
    count = 0;
    tries = 0;
    while (count < PICK_COUNT && tries < MAX_ATTEMPTS) begin
      gen_z_shadow = 32'(MULT_Z) * 32'(gen_z_shadow[15:0]) + 32'(gen_z_shadow[31:16]);
      gen_w_shadow = 32'(MULT_W) * 32'(gen_w_shadow[15:0]) + 32'(gen_w_shadow[31:16]);
      draw = (gen_z_shadow << 16) + gen_w_shadow;
      v = int'(draw % 32'(RANGE_TOP)) + 1;
      tries++;
      if (!taken[v]) begin
        taken[v] = 1'b1;
        vals[count] = VAL_W'(v);
        count++;
      end
    end
    // A generator stuck in a short cycle: top up with the smallest free values.
    for (int k = 1; k <= RANGE_TOP && count < PICK_COUNT; k++) begin
      if (!taken[k]) begin
        taken[k] = 1'b1;
        vals[count] = VAL_W'(k);
        count++;
      end
    end
    for (int i = 0; i + 1 < PICK_COUNT; i++) begin
      for (int j = i + 1; j < PICK_COUNT; j++) begin
        if (vals[i] > vals[j]) begin
          tmp = vals[i];
          vals[i] = vals[j];
          vals[j] = tmp;
        end
      end
    end
    for (int i = 0; i < PICK_COUNT; i++) begin
      r.tag   = tag;
      r.pos   = POS_W'(i);
      r.value = vals[i];
      r.last  = (i == PICK_COUNT - 1);
      pending_draws.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_drawn_value();
    draw_result_t want;
    if (pending_draws.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, actual tdata %h",
               $time, out_tdata);
      mismatch_count++;
    end else begin
      want = pending_draws.pop_front();
      check_field("column_tag", want.tag, out_tdata[7:0]);
      check_field("position", want.pos, out_tdata[10:8]);
      check_field("drawn_value", want.value, out_tdata[17:11]);
      check_field("tdata padding", 0, out_tdata[23:18]);
      check_field("last_value", want.last, out_tlast);
    end
  endtask

  // Both channels are sampled at the rising edge; inputs only move on the
  // falling edge, so nothing here races the block's own flops.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_draw(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        check_drawn_value();
      end
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [TAG_W-1:0] tag);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tdata  = tag;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // The seed is only loaded once every queued result has been taken.
  task automatic write_seed(input logic [31:0] seed);
    while (pending_draws.size() != 0) @(negedge clk);
    cfg_wr_data  = seed;
    cfg_wr_en    = 1'b1;
    gen_z_shadow = seed;
    gen_w_shadow = seed ^ SEED_XOR;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int          sent;
    int          phase_len;
    logic [31:0] seed;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    gen_z_shadow = SEED_INIT;
    gen_w_shadow = SEED_INIT ^ SEED_XOR;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_N; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_SEED) begin
        write_seed(DIRECTED_ROWS[i].value);
      end else begin
        send_request(DIRECTED_ROWS[i].value[TAG_W-1:0]);
      end
    end

    // Random phases, each under a fresh seed; the closing phase runs
    // without any idling on either side.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 30);
      if (RANDOM_ITEMS - sent <= 30) begin
        phase_len  = RANDOM_ITEMS - sent;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 7))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hFFFF_FFFF;
        2:       seed = SEED_XOR;
        3:       seed = Z_FIXED_SEED;
        4:       seed = W_FIXED_SEED;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      repeat (phase_len) send_request(TAG_W'($urandom_range(0, 255)));
      sent += phase_len;
    end

    while (pending_draws.size() != 0) @(posedge clk);
    // Catch any stray transaction the block might still emit.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rsdd_pkg.sv
hdl/rsdd_ctrl.sv
hdl/rsdd_dp.sv
hdl/random_sorted_distinct_draw_unit.sv
hdl/rsdd_checker.sv
tb/tb_random_sorted_distinct_draw_unit.sv
